// ----- hw/rtl/att_pkg.sv -----
// Shared types, codes and helpers of the ANSI text terminal engine.
`default_nettype none

package att_pkg;

    // Screen geometry defaults
    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    // Field widths
    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int CLR_W = 4;

    // Reset values of the default colors
    localparam logic [CLR_W-1:0] DFLT_FG_RST = 4'd10;
    localparam logic [CLR_W-1:0] DFLT_BG_RST = 4'd0;

    // Byte codes
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_4      = 8'h34;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;

    // Configuration register indexes
    localparam logic CFG_DFLT_FG = 1'b0;
    localparam logic CFG_DFLT_BG = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_SCROLL = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_ESC    = 3'd1,
        PH_CSI    = 3'd2,
        PH_CSI2   = 3'd3,
        PH_LEAD   = 3'd4,
        PH_DIGIT  = 3'd5,
        PH_SKIP   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_FG   = 2'd2,
        TGT_BG   = 2'd3
    } t_target;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CLR_W-1:0] fg;
        logic [CLR_W-1:0] bg;
        logic             wrap;
        t_phase           phase;
        logic             bright;
        t_target          target;
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [7:0]       glyph;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [CLR_W-1:0] fg;
        logic [CLR_W-1:0] bg;
    } t_res;

    // One or two results caused by a single byte
    typedef struct packed {
        logic two;
        t_res first;
        t_res second;
    } t_pair;

    // ANSI color number to VGA palette index
    function automatic logic [2:0] ansi_to_vga(input logic [2:0] d);
        logic [2:0] v;
        case (d)
            3'd0: v = 3'd0;
            3'd1: v = 3'd4;
            3'd2: v = 3'd2;
            3'd3: v = 3'd6;
            3'd4: v = 3'd1;
            3'd5: v = 3'd5;
            3'd6: v = 3'd3;
            default: v = 3'd7;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/att_ifs.sv -----
// Valid/ready channel interfaces for the byte stream and the display commands.
`default_nettype none

interface att_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface att_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] glyph;
    logic [4:0] row;
    logic [6:0] column;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic       last;

    modport source (output valid, output op, output glyph, output row, output column,
                    output fg_color, output bg_color, output last, input ready);
    modport sink   (input valid, input op, input glyph, input row, input column,
                    input fg_color, input bg_color, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/att_step.sv -----
// Per-byte next-state and display-command logic of the terminal.
`default_nettype none

module att_step #(
    parameter int COLS = att_pkg::COLS_DEF,
    parameter int ROWS = att_pkg::ROWS_DEF
) (
    input  att_pkg::t_state    i_state,
    input  logic [7:0]         i_byte,
    input  logic [3:0]         i_dflt_fg,
    input  logic [3:0]         i_dflt_bg,
    output att_pkg::t_state    o_state,
    output att_pkg::t_pair     o_pair,
    output logic               o_has_res
);
    import att_pkg::*;

    logic [COL_W:0] col_inc;
    logic [ROW_W:0] row_inc;
    logic           col_wraps;
    logic           row_bottom;
    logic           do_plain;
    logic [2:0]     vga;
    logic [3:0]     color;
    t_state         ns;
    t_pair          pair;
    logic           has_res;

    function automatic t_state color_lead(input t_state s, input logic [7:0] b,
                                          input logic [3:0] dfg, input logic [3:0] dbg);
        t_state r;
        r = s;
        case (b)
            CH_3: begin
                r.target = TGT_FG; r.bright = 1'b0; r.phase = PH_DIGIT;
            end
            CH_4: begin
                r.target = TGT_BG; r.bright = 1'b0; r.phase = PH_DIGIT;
            end
            CH_9: begin
                r.target = TGT_FG; r.bright = 1'b1; r.phase = PH_DIGIT;
            end
            CH_1: begin
                r.target = TGT_BG; r.bright = 1'b1; r.phase = PH_SKIP;
            end
            CH_0: begin
                r.fg = dfg; r.bg = dbg; r.target = TGT_NONE; r.bright = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_res mk_res(input t_op op, input logic [7:0] g,
                                    input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                    input logic [3:0] fg, input logic [3:0] bg);
        t_res x;
        x.op     = op;
        x.glyph  = g;
        x.row    = r;
        x.column = c;
        x.fg     = fg;
        x.bg     = bg;
        return x;
    endfunction

    assign col_inc    = {1'b0, i_state.col} + (COL_W+1)'(1);
    assign row_inc    = {1'b0, i_state.row} + (ROW_W+1)'(1);
    assign col_wraps  = col_inc >= (COL_W+1)'(COLS);
    assign row_bottom = row_inc >= (ROW_W+1)'(ROWS);
    assign vga        = ansi_to_vga(i_byte[2:0]);
    assign color      = {i_state.bright, vga};

    always_comb begin
        ns       = i_state;
        pair     = '0;
        has_res  = 1'b0;
        do_plain = 1'b0;

        case (i_state.phase)
            PH_ESC: begin
                ns.phase = PH_NORMAL;
                if (i_byte == CH_LBRACK) begin
                    ns.phase = PH_CSI;
                end else begin
                    do_plain = 1'b1;
                end
            end
            PH_CSI: begin
                ns.phase = PH_NORMAL;
                if (i_byte == CH_H) begin
                    ns.row = '0;
                    ns.col = '0;
                end else if (i_byte == CH_2) begin
                    ns.phase = PH_CSI2;
                end else if (i_byte inside {CH_3, CH_4, CH_9, CH_1, CH_0}) begin
                    ns.phase  = PH_LEAD;
                    ns.target = TGT_NONE;
                    ns.bright = 1'b0;
                    ns = color_lead(ns, i_byte, i_dflt_fg, i_dflt_bg);
                end else begin
                    do_plain = 1'b1;
                end
            end
            PH_CSI2: begin
                ns.phase = PH_NORMAL;
                if (i_byte == CH_J) begin
                    has_res    = 1'b1;
                    pair.first = mk_res(OP_CLEAR, CH_SPACE, '0, '0, i_state.fg, i_state.bg);
                end else begin
                    do_plain = 1'b1;
                end
            end
            PH_LEAD: begin
                if (i_byte == CH_M) begin
                    ns.phase = PH_NORMAL;
                end else begin
                    ns = color_lead(ns, i_byte, i_dflt_fg, i_dflt_bg);
                end
            end
            PH_SKIP: begin
                ns.phase = PH_DIGIT;
            end
            PH_DIGIT: begin
                if (i_byte == CH_M) begin
                    ns.phase = PH_NORMAL;
                end else if (i_byte inside {[CH_0:CH_7]}) begin
                    if (i_state.target == TGT_BG) begin
                        ns.bg = color;
                    end else begin
                        ns.fg = color;
                    end
                    ns.target = TGT_NONE;
                    ns.bright = 1'b0;
                    ns.phase  = PH_LEAD;
                end
            end
            default: begin
                ns.phase = PH_NORMAL;
                if (i_byte == CH_ESC) begin
                    ns.phase = PH_ESC;
                end else begin
                    do_plain = 1'b1;
                end
            end
        endcase

        // Plain byte handling: BS, LF and CR move the cursor, DEL puts a space, anything else is drawn
        if (do_plain) begin
            case (i_byte)
                CH_BS: begin
                    if (i_state.col != '0) begin
                        ns.col = i_state.col - COL_W'(1);
                    end else begin
                        ns.col = COL_W'(COLS - 1);
                        if (i_state.row != '0) begin
                            ns.row = i_state.row - ROW_W'(1);
                        end
                    end
                end
                CH_LF: begin
                    if (!i_state.wrap) begin
                        ns.col = '0;
                        if (row_bottom) begin
                            ns.row     = ROW_W'(ROWS - 1);
                            has_res    = 1'b1;
                            pair.first = mk_res(OP_SCROLL, CH_SPACE, '0, '0,
                                                i_state.fg, i_state.bg);
                        end else begin
                            ns.row = row_inc[ROW_W-1:0];
                        end
                    end
                end
                CH_CR: begin
                    ns.col = '0;
                end
                CH_DEL: begin
                    has_res    = 1'b1;
                    pair.first = mk_res(OP_PUT, CH_SPACE, i_state.row, i_state.col,
                                        i_state.fg, i_state.bg);
                end
                default: begin
                    has_res    = 1'b1;
                    ns.wrap    = 1'b0;
                    pair.first = mk_res(OP_PUT, i_byte, i_state.row, i_state.col,
                                        i_state.fg, i_state.bg);
                    ns.col     = col_inc[COL_W-1:0];
                    if (col_wraps) begin
                        ns.wrap = 1'b1;
                        ns.col  = '0;
                        if (row_bottom) begin
                            ns.row      = ROW_W'(ROWS - 1);
                            pair.two    = 1'b1;
                            pair.second = mk_res(OP_SCROLL, CH_SPACE, '0, '0,
                                                 i_state.fg, i_state.bg);
                        end else begin
                            ns.row = row_inc[ROW_W-1:0];
                        end
                    end
                end
            endcase
        end

        if (ns.phase inside {PH_NORMAL, PH_ESC, PH_CSI, PH_CSI2}) begin
            ns.target = TGT_NONE;
            ns.bright = 1'b0;
        end
    end

    assign o_state   = ns;
    assign o_pair    = pair;
    assign o_has_res = has_res;

endmodule

`default_nettype wire

// ----- hw/rtl/att_outq.sv -----
// Two-entry result queue that drains one display command per transfer.
`default_nettype none

module att_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  att_pkg::t_pair  i_pair,
    output logic            o_room,
    att_res_if.source       o_res
);
    import att_pkg::*;

    t_pair      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       r_sub;
    logic [1:0] n_cnt;

    t_pair      head;
    t_res       cur;
    logic       head_last;
    logic       xfer;
    logic       pop_pair;
    logic       push_ok;

    assign head      = r_slot[r_rp];
    assign cur       = r_sub ? head.second : head.first;
    assign head_last = !head.two || r_sub;
    assign o_room    = r_cnt != 2'd2;
    assign push_ok   = i_push && o_room;
    assign xfer      = o_res.valid && o_res.ready;
    assign pop_pair  = xfer && head_last;

    assign o_res.valid    = r_cnt != 2'd0;
    assign o_res.op       = cur.op;
    assign o_res.glyph    = cur.glyph;
    assign o_res.row      = cur.row;
    assign o_res.column   = cur.column;
    assign o_res.fg_color = cur.fg;
    assign o_res.bg_color = cur.bg;
    assign o_res.last     = head_last;

    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !pop_pair) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push_ok && pop_pair) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wp] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_sub <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push_ok) begin
                r_wp <= !r_wp;
            end
            if (pop_pair) begin
                r_rp  <= !r_rp;
                r_sub <= 1'b0;
            end else if (xfer) begin
                r_sub <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ansi_text_terminal_engine.sv -----
// Top level of the ANSI text terminal engine: state registers, config and queue.
//
//  channel   dir  handshake      payload
//  i_byte    in   valid/ready    byte_in[7:0]
//  o_res     out  valid/ready    op, glyph, row, column, fg_color, bg_color, last
//  i_cfg_*   in   write enable   index[0] (0 default_fg, 1 default_bg), wdata[3:0]
//
// When a byte is taken, its display commands are written into a
// two-entry result queue at the same edge and the cursor/parser state updates.
// The queue drains one command per transfer, so a byte that wraps at the
// bottom row (glyph plus scroll) holds the output for two transfers.
// Input ready drops only while the queue holds two unfinished byte results.
// Reset is synchronous and clears cursor, colors and parser.
`default_nettype none

module ansi_text_terminal_engine #(
    parameter int COLS = att_pkg::COLS_DEF,
    parameter int ROWS = att_pkg::ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    att_byte_if.sink   i_byte,
    att_res_if.source  o_res,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_wdata
);
    import att_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [3:0] r_dflt_fg;
    logic [3:0] r_dflt_bg;
    t_pair      step_pair;
    logic       step_has_res;
    logic       room;
    logic       accept;

    // Take a byte whenever the queue can hold its results
    assign i_byte.ready = room;
    assign accept       = i_byte.valid && room;

    att_step #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_step (
        .i_state   (r_state),
        .i_byte    (i_byte.byte_in),
        .i_dflt_fg (r_dflt_fg),
        .i_dflt_bg (r_dflt_bg),
        .o_state   (n_state),
        .o_pair    (step_pair),
        .o_has_res (step_has_res)
    );

    att_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && step_has_res),
        .i_pair  (step_pair),
        .o_room  (room),
        .o_res   (o_res)
    );

    // Default colors; the user must write them only while the engine is idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt_fg <= DFLT_FG_RST;
            r_dflt_bg <= DFLT_BG_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DFLT_FG: r_dflt_fg <= i_cfg_wdata;
                CFG_DFLT_BG: r_dflt_bg <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance cursor, colors and parser on every accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.row    <= '0;
            r_state.col    <= '0;
            r_state.fg     <= DFLT_FG_RST;
            r_state.bg     <= DFLT_BG_RST;
            r_state.wrap   <= 1'b0;
            r_state.phase  <= PH_NORMAL;
            r_state.bright <= 1'b0;
            r_state.target <= TGT_NONE;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- bench/ansi_text_terminal_engine_tb.sv -----
// Self-checking testbench of the ANSI text terminal engine: byte stream in, display commands out.
module ansi_text_terminal_engine_tb;
    import att_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int TIMEOUT_UNITS = 4_000_000;
    localparam int N_COLS        = COLS_DEF;
    localparam int N_ROWS        = ROWS_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 40;

    // Separator inside a color sequence; the parser ignores it
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // ANSI color number to VGA palette index (low three bits)
    localparam logic [2:0] ANSI_VGA [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    // Bytes that open a color group after ESC[
    localparam logic [7:0] COLOR_LEADERS [5] = '{CH_3, CH_4, CH_9, CH_1, CH_0};

    // One expected display command
    typedef struct {
        t_op              op;
        logic [7:0]       glyph;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [CLR_W-1:0] fg;
        logic [CLR_W-1:0] bg;
        logic             last;
    } t_display_cmd;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [3:0] cfg_wdata;

    att_byte_if byte_if ();
    att_res_if  res_if ();

    ansi_text_terminal_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_if),
        .o_res       (res_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Screen model: cursor, colors, wrap flag and escape parser
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic [CLR_W-1:0] cur_fg;
    logic [CLR_W-1:0] cur_bg;
    logic [CLR_W-1:0] dflt_fg;
    logic [CLR_W-1:0] dflt_bg;
    logic             wrap_pend;
    t_phase           phase;
    logic             bright;
    t_target          target;

    t_display_cmd pending_cmds [$];   // commands still owed by the block, oldest first
    t_display_cmd byte_cmds [$];      // commands caused by the byte being modeled
    logic [7:0]   text_queue [$];     // bytes lined up for the sender

    int sender_gap_pct;
    int sink_stall_pct;
    int mismatch_count;

    // ------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------
    task automatic reset_screen_model();
        dflt_fg   = DFLT_FG_RST;
        dflt_bg   = DFLT_BG_RST;
        cur_row   = '0;
        cur_col   = '0;
        cur_fg    = DFLT_FG_RST;
        cur_bg    = DFLT_BG_RST;
        wrap_pend = 1'b0;
        phase     = PH_NORMAL;
        bright    = 1'b0;
        target    = TGT_NONE;
        pending_cmds.delete();
    endtask

    // A byte causes at most two commands; colors are taken at the moment of issue
    task automatic add_cmd(input t_op op, input logic [7:0] glyph,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column);
        t_display_cmd cmd;
        if (byte_cmds.size() < 2) begin
            cmd.op     = op;
            cmd.glyph  = glyph;
            cmd.row    = row;
            cmd.column = column;
            cmd.fg     = cur_fg;
            cmd.bg     = cur_bg;
            cmd.last   = 1'b0;
            byte_cmds.push_back(cmd);
        end
    endtask

    task automatic advance_line();
        cur_row = cur_row + 1'b1;
        cur_col = '0;
        if (cur_row >= N_ROWS) begin
            add_cmd(OP_SCROLL, CH_SPACE, '0, '0);
            cur_row = ROW_W'(N_ROWS - 1);
        end
    endtask

    task automatic apply_plain(input logic [7:0] code);
        case (code)
            CH_BS: begin
                if (cur_col != 0) begin
                    cur_col = cur_col - 1'b1;
                end else begin
                    cur_col = COL_W'(N_COLS - 1);
                    if (cur_row != 0) cur_row = cur_row - 1'b1;
                end
            end
            CH_LF: begin
                // swallowed right after an auto-wrap
                if (!wrap_pend) advance_line();
            end
            CH_CR: begin
                cur_col = '0;
            end
            CH_DEL: begin
                add_cmd(OP_PUT, CH_SPACE, cur_row, cur_col);
            end
            default: begin
                wrap_pend = 1'b0;
                add_cmd(OP_PUT, code, cur_row, cur_col);
                cur_col = cur_col + 1'b1;
                if (cur_col >= N_COLS) begin
                    advance_line();
                    wrap_pend = 1'b1;
                end
            end
        endcase
    endtask

    task automatic apply_leader(input logic [7:0] code);
        case (code)
            CH_3: begin target = TGT_FG; bright = 1'b0; phase = PH_DIGIT; end
            CH_4: begin target = TGT_BG; bright = 1'b0; phase = PH_DIGIT; end
            CH_9: begin target = TGT_FG; bright = 1'b1; phase = PH_DIGIT; end
            CH_1: begin target = TGT_BG; bright = 1'b1; phase = PH_SKIP; end
            CH_0: begin
                cur_fg = dflt_fg;
                cur_bg = dflt_bg;
                target = TGT_NONE;
                bright = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Work out the commands of one accepted byte and queue them for checking
    task automatic advance_screen_model(input logic [7:0] code);
        logic [CLR_W-1:0] shade;
        byte_cmds.delete();
        case (phase)
            PH_ESC: begin
                phase = PH_NORMAL;
                if (code == CH_LBRACK) phase = PH_CSI;
                else apply_plain(code);
            end
            PH_CSI: begin
                phase = PH_NORMAL;
                if (code == CH_H) begin
                    // home keeps the wrap flag
                    cur_row = '0;
                    cur_col = '0;
                end else if (code == CH_2) begin
                    phase = PH_CSI2;
                end else if (code inside {CH_3, CH_4, CH_9, CH_1, CH_0}) begin
                    phase  = PH_LEAD;
                    target = TGT_NONE;
                    bright = 1'b0;
                    apply_leader(code);
                end else begin
                    apply_plain(code);
                end
            end
            PH_CSI2: begin
                phase = PH_NORMAL;
                if (code == CH_J) add_cmd(OP_CLEAR, CH_SPACE, '0, '0);
                else apply_plain(code);
            end
            PH_LEAD: begin
                if (code == CH_M) phase = PH_NORMAL;
                else apply_leader(code);
            end
            PH_SKIP: begin
                phase = PH_DIGIT;
            end
            PH_DIGIT: begin
                if (code == CH_M) begin
                    phase = PH_NORMAL;
                end else if (code >= CH_0 && code <= CH_7) begin
                    shade = {bright, ANSI_VGA[code[2:0]]};
                    if (target == TGT_BG) cur_bg = shade;
                    else cur_fg = shade;
                    target = TGT_NONE;
                    bright = 1'b0;
                    phase  = PH_LEAD;
                end
            end
            default: begin
                phase = PH_NORMAL;
                if (code == CH_ESC) phase = PH_ESC;
                else apply_plain(code);
            end
        endcase
        if (phase inside {PH_NORMAL, PH_ESC, PH_CSI, PH_CSI2}) begin
            target = TGT_NONE;
            bright = 1'b0;
        end
        if (byte_cmds.size() > 0) byte_cmds[byte_cmds.size() - 1].last = 1'b1;
        foreach (byte_cmds[k]) pending_cmds.push_back(byte_cmds[k]);
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Enter at a falling edge; leave at a falling edge with valid still high,
    // so back-to-back bytes never see valid dropped and raised in one step.
    task automatic send_text_byte(input logic [7:0] code);
        while ($urandom_range(99) < sender_gap_pct) begin
            byte_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.byte_in <= code;
        do @(posedge i_clk); while (!byte_if.ready);
        advance_screen_model(code);
        @(negedge i_clk);
    endtask

    task automatic send_queued_text();
        while (text_queue.size() != 0) send_text_byte(text_queue.pop_front());
    endtask

    // Hold the input off until every owed command has come, then let the block settle
    task automatic wait_screen_idle();
        byte_if.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write both default colors back to back; call only while idle
    task automatic set_default_colors(input logic [3:0] fg, input logic [3:0] bg);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DFLT_FG;
        cfg_wdata <= fg;
        @(negedge i_clk);
        cfg_index <= CFG_DFLT_BG;
        cfg_wdata <= bg;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        dflt_fg = fg;
        dflt_bg = bg;
    endtask

    function automatic logic [7:0] pick_glyph();
        logic [7:0] g;
        do g = 8'($urandom_range(255));
        while (g inside {CH_BS, CH_LF, CH_CR, CH_DEL, CH_ESC});
        return g;
    endfunction

    // ESC[ then one to three color groups, closed by 'm'; noisy adds junk bytes
    task automatic queue_color_sequence(input bit noisy);
        int         groups;
        logic [7:0] leader;
        text_queue.push_back(CH_ESC);
        text_queue.push_back(CH_LBRACK);
        groups = $urandom_range(1, 3);
        for (int g = 0; g < groups; g++) begin
            if (g > 0 && $urandom_range(1)) text_queue.push_back(CH_SEMI);
            leader = COLOR_LEADERS[$urandom_range(4)];
            text_queue.push_back(leader);
            if (leader == CH_1)
                text_queue.push_back($urandom_range(1) ? CH_0 : 8'($urandom_range(255)));
            if (noisy && $urandom_range(1)) text_queue.push_back(8'($urandom_range(255)));
            if (leader != CH_0) text_queue.push_back(CH_0 + 8'($urandom_range(7)));
        end
        text_queue.push_back(CH_M);
    endtask

    // One well-formed or broken piece of a text stream
    task automatic queue_random_unit();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            repeat ($urandom_range(1, 6)) text_queue.push_back(pick_glyph());
        end else if (pick < 65) begin
            case ($urandom_range(3))
                0: text_queue.push_back(CH_BS);
                1: text_queue.push_back(CH_LF);
                2: text_queue.push_back(CH_CR);
                default: text_queue.push_back(CH_DEL);
            endcase
        end else if (pick < 73) begin
            text_queue.push_back(CH_ESC);
            text_queue.push_back(CH_LBRACK);
            if ($urandom_range(1)) begin
                text_queue.push_back(CH_H);
            end else begin
                text_queue.push_back(CH_2);
                text_queue.push_back(CH_J);
            end
        end else if (pick < 88) begin
            queue_color_sequence(1'b0);
        end else if (pick < 96) begin
            case ($urandom_range(3))
                0: begin
                    text_queue.push_back(CH_ESC);
                    text_queue.push_back(8'($urandom_range(255)));
                end
                1: begin
                    // an 'm' closes a color mode the random byte may have opened
                    text_queue.push_back(CH_ESC);
                    text_queue.push_back(CH_LBRACK);
                    text_queue.push_back(8'($urandom_range(255)));
                    text_queue.push_back(CH_M);
                end
                2: begin
                    text_queue.push_back(CH_ESC);
                    text_queue.push_back(CH_LBRACK);
                    text_queue.push_back(CH_2);
                    text_queue.push_back(8'($urandom_range(255)));
                end
                default: queue_color_sequence(1'b1);
            endcase
        end else begin
            text_queue.push_back(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side and checker
    // ------------------------------------------------------------------

    // Stall the command output at random, per the current phase
    always @(negedge i_clk) res_if.ready <= ($urandom_range(99) >= sink_stall_pct);

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Compare every command transfer with the oldest owed command
    always @(posedge i_clk) begin : check_display_cmds
        t_display_cmd want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_cmds.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected command, expected none, actual op %0d glyph %0h",
                             $time, res_if.op, res_if.glyph);
            end else begin
                want = pending_cmds.pop_front();
                check_field("op", want.op, res_if.op);
                check_field("glyph", want.glyph, res_if.glyph);
                check_field("row", want.row, res_if.row);
                check_field("column", want.column, res_if.column);
                check_field("fg_color", want.fg, res_if.fg_color);
                check_field("bg_color", want.bg, res_if.bg_color);
                check_field("last", want.last, res_if.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Control bytes and extreme glyph codes, including a wrap on the top row
    task automatic test_text_controls();
        text_queue.push_back(CH_BS);      // top-left: jump to the last column, row stays
        text_queue.push_back(8'h41);      // draws in the last column and wraps
        text_queue.push_back(CH_LF);      // swallowed after the wrap
        text_queue.push_back(8'h00);
        text_queue.push_back(8'hFF);
        text_queue.push_back(CH_DEL);     // space at the cursor, cursor stays
        text_queue.push_back(CH_BS);
        text_queue.push_back(CH_CR);
        text_queue.push_back(CH_LF);
        send_queued_text();
    endtask

    // Clear, a bright color sequence, home, and escapes that fall back to text
    task automatic test_escape_sequences();
        text_queue = '{CH_ESC, CH_LBRACK, CH_2, CH_J,
                       // bright background with its skipped byte, then bright foreground
                       CH_ESC, CH_LBRACK, CH_1, 8'h78, CH_2, CH_9, CH_7, CH_M,
                       CH_ESC, CH_LBRACK, CH_H,
                       CH_ESC, CH_ESC,                 // second ESC is drawn
                       CH_ESC, CH_LBRACK, 8'h5A,       // unknown CSI byte is drawn
                       CH_ESC, CH_LBRACK, CH_2, 8'h78};
        send_queued_text();
    endtask

    // Scroll at the bottom row, a glyph that wraps and scrolls, newlines after it
    task automatic test_wrap_and_scroll();
        text_queue.push_back(CH_CR);
        repeat (N_ROWS + 1) text_queue.push_back(CH_LF);
        repeat (N_COLS) text_queue.push_back(pick_glyph());
        text_queue.push_back(CH_LF);
        text_queue.push_back(CH_LF);
        text_queue.push_back(pick_glyph());
        text_queue.push_back(CH_ESC);
        text_queue.push_back(CH_LBRACK);
        text_queue.push_back(CH_H);
        text_queue.push_back(pick_glyph());
        send_queued_text();
    endtask

    // Color reset picks up the default registers at both extremes
    task automatic test_default_colors();
        logic [3:0] fg_vals [2] = '{4'd0, 4'd15};
        logic [3:0] bg_vals [2] = '{4'd15, 4'd0};
        for (int k = 0; k < 2; k++) begin
            wait_screen_idle();
            set_default_colors(fg_vals[k], bg_vals[k]);
            text_queue = '{CH_ESC, CH_LBRACK, CH_0, CH_M, 8'h61};
            send_queued_text();
        end
    endtask

    // Random streams under four idling mixes, new defaults before each
    task automatic test_random_stream();
        int gap_pct [4]   = '{0, 71, 0, 38};
        int stall_pct [4] = '{0, 0, 71, 38};
        int sent;
        for (int p = 0; p < 4; p++) begin
            wait_screen_idle();
            set_default_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
            sender_gap_pct = gap_pct[p];
            sink_stall_pct = stall_pct[p];
            sent = 0;
            while (sent < 470) begin
                queue_random_unit();
                sent += text_queue.size();
                send_queued_text();
            end
        end
        sender_gap_pct = 0;
        sink_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // drive every input to a known value from time zero
        i_rst_n         = 1'b0;
        byte_if.valid   = 1'b0;
        byte_if.byte_in = 8'h00;
        res_if.ready    = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_DFLT_FG;
        cfg_wdata       = 4'd0;
        sender_gap_pct  = 0;
        sink_stall_pct  = 0;
        mismatch_count  = 0;
        reset_screen_model();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_text_controls();
        test_escape_sequences();
        test_wrap_and_scroll();
        test_default_colors();
        test_random_stream();

        // drain, then give the block a few more cycles to show stray commands
        wait_screen_idle();
        repeat (16) @(negedge i_clk);
        if (mismatch_count == 0 && pending_cmds.size() == 0) begin
            $display("ansi_text_terminal_engine_tb OK");
        end else begin
            $display("ansi_text_terminal_engine_tb NOT OK");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_UNITS);
        $display("ansi_text_terminal_engine_tb NOT OK");
        $finish;
    end

endmodule
